@@ hdl/rej_pkg.sv @@
package rej_pkg;

	// pose storage
	localparam int NUM_POSES  = 256;
	localparam int POSE_AW    = $clog2(NUM_POSES);
	localparam int POSE_WORDS = 12;
	localparam int WORD_AW    = 4;
	localparam int ROT_WORDS  = 9;

	// pipelined divider: abs stage, one stage per quotient bit, sign stage
	localparam int DIV_STEPS = 64;
	localparam int DIV_LAT   = DIV_STEPS + 2;

	// number of Jacobian entries
	localparam int NUM_JAC = 6;

	// register reset values (unsigned Q15.16)
	localparam logic [30:0] FOCAL_X_RST  = 31'd37158912;
	localparam logic [30:0] FOCAL_Y_RST  = 31'd37158912;
	localparam logic [30:0] CENTER_X_RST = 31'd20938752;
	localparam logic [30:0] CENTER_Y_RST = 31'd15695872;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;
	localparam logic signed [63:0] Q1_LIM  = 64'sh0000_8000_0000_0000;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_FOCAL_X  = 2'd0,
		CFG_FOCAL_Y  = 2'd1,
		CFG_CENTER_X = 2'd2,
		CFG_CENTER_Y = 2'd3
	} cfg_idx_t;

	// side data that rides along the first divider bank
	typedef struct packed {
		logic signed [31:0] z;
		logic signed [32:0] off_u;
		logic signed [32:0] off_v;
	} side1_t;

	// side data that rides along the second divider bank
	typedef struct packed {
		logic               z_zero;
		logic               z_nonpos;
		logic signed [31:0] res_u;
		logic signed [31:0] res_v;
		logic [NUM_JAC-1:0] big;
		logic [NUM_JAC-1:0] sat_neg;
	} side2_t;

	typedef struct packed {
		logic         fault;
		logic [255:0] data;
	} result_t;

	// clamp a 64-bit signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'(SAT_MAX))
			r = SAT_MAX;
		else if (v < 64'(SAT_MIN))
			r = SAT_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

@@ hdl/rej_div.sv @@
// Pipelined signed divider, quotient truncated toward zero.
// One restoring step per stage; en freezes every stage.
module rej_div (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] dividend,
	input  logic signed [31:0] divisor,
	output logic signed [63:0] quotient
);

	logic [63:0] work_q [rej_pkg::DIV_STEPS+1];
	logic [31:0] rem_q  [rej_pkg::DIV_STEPS+1];
	logic [31:0] dmag_q [rej_pkg::DIV_STEPS+1];
	logic        neg_q  [rej_pkg::DIV_STEPS+1];

	logic [63:0] work_n [rej_pkg::DIV_STEPS];
	logic [31:0] rem_n  [rej_pkg::DIV_STEPS];

	// one quotient bit per stage
	always_comb begin
		logic [32:0] trial;
		logic        ge;
		for (int k = 0; k < rej_pkg::DIV_STEPS; k++) begin
			trial     = {rem_q[k], work_q[k][63]};
			ge        = trial >= {1'b0, dmag_q[k]};
			rem_n[k]  = ge ? 32'(trial - {1'b0, dmag_q[k]}) : trial[31:0];
			work_n[k] = {work_q[k][62:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and result sign
			work_q[0] <= dividend[63] ? 64'(-dividend) : dividend;
			dmag_q[0] <= divisor[31] ? 32'(-divisor) : divisor;
			rem_q[0]  <= '0;
			neg_q[0]  <= dividend[63] ^ divisor[31];
			for (int k = 0; k < rej_pkg::DIV_STEPS; k++) begin
				work_q[k+1] <= work_n[k];
				rem_q[k+1]  <= rem_n[k];
				dmag_q[k+1] <= dmag_q[k];
				neg_q[k+1]  <= neg_q[k];
			end
			quotient <= neg_q[rej_pkg::DIV_STEPS] ? 64'(-work_q[rej_pkg::DIV_STEPS])
			                                      : work_q[rej_pkg::DIV_STEPS];
		end
	end

endmodule

@@ hdl/reprojection_error_jacobian.sv @@
// Pinhole reprojection residual and point Jacobian, fixed point.
// Input stream (s_*): s_tuser selects the command. A write item stores one
// pose word (12 words per pose, 9 rotation Q2.30 then 3 translation Q16.16)
// and gives no result. An evaluate item maps the world point through the
// stored pose, projects it and returns one result on m_*: residuals,
// the 2x3 Jacobian (Q16.16, saturated) and a depth flag in m_tuser.
// Configuration (cfg_*): focal lengths and principal point, always ready;
// it must be written only while no evaluate item is in flight; the block does not enforce this.
// Throughput: one item per cycle while the pipeline is not held. From acceptance
// to m_tvalid an item passes through two chained 66-stage bit-per-stage dividers
// (projection and Jacobian numerator, then the Jacobian scale step),
// seven arithmetic stages and the output register.
// Reset clears all valid bits and loads the default camera constants; the
// pose table is not cleared and holds garbage until written.
// When the receiver stalls, one more result lands in a skid register,
// after which s_tready drops and the whole pipeline holds.
module reprojection_error_jacobian (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pose_index[7:0] word_index[11:8] word_value[43:12] point_x[75:44]
	// point_y[107:76] point_z[139:108] pixel_u[171:140] pixel_v[203:172]
	input  logic [207:0] s_tdata,
	// command[0]
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// residual_u[31:0] residual_v[63:32] jac_u_dx[95:64] jac_u_dy[127:96]
	// jac_u_dz[159:128] jac_v_dx[191:160] jac_v_dy[223:192] jac_v_dz[255:224]
	output logic [255:0] m_tdata,
	// depth_fault[0]
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [30:0]  cfg_data
);

	localparam int NJ = rej_pkg::NUM_JAC;
	localparam int DL = rej_pkg::DIV_LAT;

	// ---------------------------------------------------------------- fields
	logic [7:0]                      in_pose;
	logic [rej_pkg::WORD_AW-1:0]     in_word;
	logic [31:0]                     in_value;
	logic signed [31:0]              in_pt [3];
	logic signed [31:0]              in_pix_u, in_pix_v;
	logic                            in_acc, in_pose_ok;
	logic                            adv;

	assign in_pose   = s_tdata[7:0];
	assign in_word   = s_tdata[11:8];
	assign in_value  = s_tdata[43:12];
	assign in_pt[0]  = s_tdata[75:44];
	assign in_pt[1]  = s_tdata[107:76];
	assign in_pt[2]  = s_tdata[139:108];
	assign in_pix_u  = s_tdata[171:140];
	assign in_pix_v  = s_tdata[203:172];
	assign in_acc    = s_tvalid && s_tready;
	assign in_pose_ok = {1'b0, in_pose} < 9'(rej_pkg::NUM_POSES);

	// ---------------------------------------------------------------- config
	logic [30:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= rej_pkg::FOCAL_X_RST;
			focal_y_q  <= rej_pkg::FOCAL_Y_RST;
			center_x_q <= rej_pkg::CENTER_X_RST;
			center_y_q <= rej_pkg::CENTER_Y_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rej_pkg::cfg_idx_t'(cfg_index))
				rej_pkg::CFG_FOCAL_X:  focal_x_q  <= cfg_data;
				rej_pkg::CFG_FOCAL_Y:  focal_y_q  <= cfg_data;
				rej_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				rej_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- pose table
	localparam logic [rej_pkg::WORD_AW-1:0] WORD_AW_LIM = rej_pkg::WORD_AW'(rej_pkg::POSE_WORDS);

	// one bank per pose word, so all twelve words are read together
	logic [31:0] pose_mem [rej_pkg::POSE_WORDS][rej_pkg::NUM_POSES];
	logic [31:0] rd_s1 [rej_pkg::POSE_WORDS];

	always_ff @(posedge clk) begin
		if (in_acc && (rej_pkg::cmd_t'(s_tuser[0]) == rej_pkg::CMD_WRITE) && in_pose_ok &&
		    (in_word < WORD_AW_LIM))
			pose_mem[in_word][in_pose[rej_pkg::POSE_AW-1:0]] <= in_value;
		if (adv)
			for (int w = 0; w < rej_pkg::POSE_WORDS; w++)
				rd_s1[w] <= pose_mem[w][in_pose[rej_pkg::POSE_AW-1:0]];
	end

	// ---------------------------------------------------------------- s1: capture
	logic               v_s1, ok_s1;
	logic signed [31:0] pt_s1 [3];
	logic signed [31:0] pix_u_s1, pix_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= in_acc && (rej_pkg::cmd_t'(s_tuser[0]) == rej_pkg::CMD_EVAL);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_s1    <= in_pose_ok;
			pt_s1    <= in_pt;
			pix_u_s1 <= in_pix_u;
			pix_v_s1 <= in_pix_v;
		end
	end

	// ---------------------------------------------------------------- s2: R*p products
	logic signed [31:0] pose_w [rej_pkg::POSE_WORDS];
	logic               v_s2;
	logic signed [63:0] prod_s2 [rej_pkg::ROT_WORDS];
	logic signed [31:0] rot_s2 [rej_pkg::ROT_WORDS];
	logic signed [31:0] tr_s2 [3];
	logic signed [31:0] pix_u_s2, pix_v_s2;

	// a pose index out of range reads as an all-zero pose
	always_comb begin
		for (int w = 0; w < rej_pkg::POSE_WORDS; w++)
			pose_w[w] = ok_s1 ? rd_s1[w] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s2[i*3+j] <= pose_w[i*3+j] * pt_s1[j];
			for (int w = 0; w < rej_pkg::ROT_WORDS; w++)
				rot_s2[w] <= pose_w[w];
			for (int i = 0; i < 3; i++)
				tr_s2[i] <= pose_w[rej_pkg::ROT_WORDS+i];
			pix_u_s2 <= pix_u_s1;
			pix_v_s2 <= pix_v_s1;
		end
	end

	// ---------------------------------------------------------------- s3: camera point
	logic               v_s3;
	logic signed [31:0] c_s3 [3];
	logic signed [31:0] rot_s3 [rej_pkg::ROT_WORDS];
	logic signed [31:0] pix_u_s3, pix_v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (adv)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				c_s3[i] <= rej_pkg::sat32((prod_s2[i*3] >>> 30) + (prod_s2[i*3+1] >>> 30) +
				                          (prod_s2[i*3+2] >>> 30) + 64'(tr_s2[i]));
			rot_s3   <= rot_s2;
			pix_u_s3 <= pix_u_s2;
			pix_v_s3 <= pix_v_s2;
		end
	end

	// ---------------------------------------------------------------- s4: products
	logic signed [31:0] fx_s, fy_s;
	logic               v_s4;
	logic signed [63:0] pu_s4, pv_s4;
	logic signed [63:0] a_s4 [NJ];
	logic signed [63:0] b_s4 [NJ];
	logic signed [31:0] z_s4;
	logic signed [32:0] off_u_s4, off_v_s4;

	assign fx_s = $signed({1'b0, focal_x_q});
	assign fy_s = $signed({1'b0, focal_y_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s4 <= 1'b0;
		else if (adv)
			v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pu_s4 <= fx_s * c_s3[0];
			pv_s4 <= fy_s * c_s3[1];
			for (int j = 0; j < 3; j++) begin
				a_s4[j]   <= rot_s3[j] * c_s3[2];
				a_s4[3+j] <= rot_s3[3+j] * c_s3[2];
				b_s4[j]   <= rot_s3[6+j] * c_s3[0];
				b_s4[3+j] <= rot_s3[6+j] * c_s3[1];
			end
			z_s4     <= c_s3[2];
			off_u_s4 <= 33'(pix_u_s3) - $signed({2'b00, center_x_q});
			off_v_s4 <= 33'(pix_v_s3) - $signed({2'b00, center_y_q});
		end
	end

	// ---------------------------------------------------------------- s5: Jacobian numerators
	logic               v_s5;
	logic signed [31:0] t_s5 [NJ];
	logic signed [63:0] pu_s5, pv_s5;
	logic signed [31:0] z_s5;
	logic signed [32:0] off_u_s5, off_v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (adv)
			v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NJ; k++)
				t_s5[k] <= rej_pkg::sat32((a_s4[k] >>> 30) - (b_s4[k] >>> 30));
			pu_s5    <= pu_s4;
			pv_s5    <= pv_s4;
			z_s5     <= z_s4;
			off_u_s5 <= off_u_s4;
			off_v_s5 <= off_v_s4;
		end
	end

	// ---------------------------------------------------------------- s6: focal * numerator
	logic               v_s6;
	logic signed [63:0] m_s6 [NJ];
	logic signed [63:0] pu_s6, pv_s6;
	logic signed [31:0] z_s6;
	logic signed [32:0] off_u_s6, off_v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (adv)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NJ; k++)
				m_s6[k] <= ((k < 3) ? fx_s : fy_s) * t_s5[k];
			pu_s6    <= pu_s5;
			pv_s6    <= pv_s5;
			z_s6     <= z_s5;
			off_u_s6 <= off_u_s5;
			off_v_s6 <= off_v_s5;
		end
	end

	// ---------------------------------------------------------------- first divider bank
	logic signed [63:0] d1_dvd [NJ+2];
	logic signed [63:0] d1_quo [NJ+2];
	logic               dl1_v_q [DL];
	rej_pkg::side1_t    dl1_q [DL];

	always_comb begin
		d1_dvd[0] = pu_s6;
		d1_dvd[1] = pv_s6;
		for (int k = 0; k < NJ; k++)
			d1_dvd[2+k] = m_s6[k];
	end

	for (genvar g = 0; g < NJ + 2; g++) begin : g_div1
		rej_div u_div (
			.clk      (clk),
			.en       (adv),
			.dividend (d1_dvd[g]),
			.divisor  (z_s6),
			.quotient (d1_quo[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DL; k++)
				dl1_v_q[k] <= 1'b0;
		end else if (adv) begin
			dl1_v_q[0] <= v_s6;
			for (int k = 1; k < DL; k++)
				dl1_v_q[k] <= dl1_v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dl1_q[0] <= '{z: z_s6, off_u: off_u_s6, off_v: off_v_s6};
			for (int k = 1; k < DL; k++)
				dl1_q[k] <= dl1_q[k-1];
		end
	end

	// ---------------------------------------------------------------- s7: residuals, scale prep
	logic               v_s7;
	logic signed [31:0] res_u_s7, res_v_s7, z_s7;
	logic [NJ-1:0]      big_s7, neg_s7;
	logic signed [63:0] dvd_s7 [NJ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s7 <= 1'b0;
		else if (adv)
			v_s7 <= dl1_v_q[DL-1];
	end

	always_ff @(posedge clk) begin
		logic signed [63:0] q;
		if (adv) begin
			res_u_s7 <= rej_pkg::sat32(d1_quo[0] - 64'(dl1_q[DL-1].off_u));
			res_v_s7 <= rej_pkg::sat32(d1_quo[1] - 64'(dl1_q[DL-1].off_v));
			z_s7     <= dl1_q[DL-1].z;
			for (int k = 0; k < NJ; k++) begin
				q = d1_quo[2+k];
				big_s7[k] <= (q >= rej_pkg::Q1_LIM) || (q <= -rej_pkg::Q1_LIM);
				neg_s7[k] <= q[63] != dl1_q[DL-1].z[31];
				dvd_s7[k] <= {q[47:0], 16'h0000};
			end
		end
	end

	// ---------------------------------------------------------------- second divider bank
	logic signed [63:0] d2_quo [NJ];
	logic               dl2_v_q [DL];
	rej_pkg::side2_t    dl2_q [DL];

	for (genvar g = 0; g < NJ; g++) begin : g_div2
		rej_div u_div (
			.clk      (clk),
			.en       (adv),
			.dividend (dvd_s7[g]),
			.divisor  (z_s7),
			.quotient (d2_quo[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DL; k++)
				dl2_v_q[k] <= 1'b0;
		end else if (adv) begin
			dl2_v_q[0] <= v_s7;
			for (int k = 1; k < DL; k++)
				dl2_v_q[k] <= dl2_v_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dl2_q[0] <= '{z_zero: (z_s7 == 32'sd0), z_nonpos: (z_s7 <= 32'sd0),
			              res_u: res_u_s7, res_v: res_v_s7, big: big_s7, sat_neg: neg_s7};
			for (int k = 1; k < DL; k++)
				dl2_q[k] <= dl2_q[k-1];
		end
	end

	// ---------------------------------------------------------------- final assembly
	rej_pkg::side2_t    side_f;
	rej_pkg::result_t   fin;
	logic               fin_v;
	logic signed [31:0] jac_f [NJ];

	assign side_f = dl2_q[DL-1];
	assign fin_v  = dl2_v_q[DL-1];

	always_comb begin
		for (int k = 0; k < NJ; k++) begin
			if (side_f.big[k])
				jac_f[k] = side_f.sat_neg[k] ? rej_pkg::SAT_MIN : rej_pkg::SAT_MAX;
			else
				jac_f[k] = rej_pkg::sat32(d2_quo[k]);
		end
		fin.fault = side_f.z_nonpos;
		fin.data  = {jac_f[5], jac_f[4], jac_f[3], jac_f[2], jac_f[1], jac_f[0],
		             side_f.res_v, side_f.res_u};
		// zero depth forces every value to zero
		if (side_f.z_zero)
			fin.data = '0;
	end

	// ---------------------------------------------------------------- output and skid
	logic             out_v_q, skid_v_q;
	rej_pkg::result_t out_q, skid_q;

	assign adv      = !skid_v_q;
	assign s_tready = adv;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q.data;
	assign m_tuser  = out_q.fault;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (m_tready)
				skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			out_v_q <= fin_v;
		end else if (fin_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (m_tready)
				out_q <= skid_q;
		end else if (!out_v_q || m_tready) begin
			out_q <= fin;
		end else begin
			skid_q <= fin;
		end
	end

	// ---------------------------------------------------------------- checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds an item while the output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(m_tvalid && !m_tready))
		else $error("skid filled without a stalled output");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (rej_pkg::cmd_t'(s_tuser[0]) == rej_pkg::CMD_WRITE) |=> !v_s1)
		else $error("write item entered the evaluate pipeline");

	a_zero_depth: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v && side_f.z_zero |-> (fin.data == '0) && fin.fault)
		else $error("zero depth result not cleared");

endmodule
